// ----- rtl/pwi_pkg.sv -----
`timescale 1ns / 1ps
package pwi_pkg;
  localparam int unsigned VALUE_W = 40;
  localparam int unsigned RAW_W = 32;
  localparam int unsigned CFG_W = 40;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [26:0] CGS_SCALE_Q16 = 27'd87374148;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT = 2'd0,
    REG_INITIAL_VALUE = 2'd1,
    REG_SCALE_TO_CGS = 2'd2,
    REG_USE_INITIAL = 2'd3
  } reg_idx_e;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_QUERY = 1'b1;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_NOT_PRESCRIBED = 1'b1;
endpackage

// ----- rtl/pwi_in_if.sv -----
`timescale 1ns / 1ps
interface pwi_in_if #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned IDX_W = 6
);
  logic valid;
  logic ready;
  logic action;
  logic [IDX_W-1:0] point_index;
  logic [TIME_BITS-1:0] point_time;
  logic signed [pwi_pkg::RAW_W-1:0] point_value;
  logic [TIME_BITS-1:0] query_time;
  modport source (output valid, action, point_index, point_time, point_value, query_time,
                  input ready);
  modport sink (input valid, action, point_index, point_time, point_value, query_time,
                output ready);
endinterface

// ----- rtl/pwi_out_if.sv -----
`timescale 1ns / 1ps
interface pwi_out_if;
  logic valid;
  logic ready;
  logic signed [pwi_pkg::VALUE_W-1:0] value;
  logic status;
  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

// ----- rtl/pwi_ram.sv -----
`timescale 1ns / 1ps
module pwi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/periodic_waveform_interpolator_unit.sv -----
`timescale 1ns / 1ps
// Channel  | Dir | Payload
// in_if    | in  | action, point_index, point_time, point_value, query_time
// out_if   | out | value, status
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i
// Load: multiply (S_LMUL), then round and write back (S_LWR).
// Query: fetch the period, then a bit-serial modulo, the segment walk, the serial multiply
// and the divide.
// Reset returns control to idle and sets the config registers to count 0, initial value 0,
// scaling off and use-initial on; the tables are undefined until loaded.
// in ready is low while an item is at work or a result waits on a stalled out.
module periodic_waveform_interpolator_unit #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pwi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pwi_pkg::CFG_W-1:0]      cfg_data_i,
  pwi_in_if.sink                         in_if,
  pwi_out_if.source                      out_if
);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned VW = pwi_pkg::VALUE_W;
  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned SW = $clog2(VW + TW + 1);
  localparam int unsigned PW = VW + TW;
  localparam int unsigned IW = 6;
  localparam int unsigned RAW_W_L = pwi_pkg::RAW_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LMUL, S_LWR, S_QRD, S_QMOD, S_RD0, S_WALK, S_WALK2, S_MUL, S_DIV,
    S_OUT
  } state_e;

  state_e state_q;
  logic [6:0] cnt_q;
  logic [CW-1:0] n_q;
  logic signed [VW-1:0] init_q;
  logic scale_q, use_init_q;

  logic [TW-1:0] qt_q, per_q, rem_q, t_q, ta_q, num_q, den_q;
  logic [IW-1:0] lidx_q;
  logic [TW-1:0] ltime_q;
  logic neg_q;
  logic [59:0] lprod_q;
  logic [RAW_W_L-1:0] lmag_q;
  logic signed [VW-1:0] va_q, vlast_q;
  logic [AW-1:0] k_q;
  logic [VW:0] mag_q;
  logic dneg_q;
  logic [PW-1:0] acc_q;
  logic [SW-1:0] bit_q;
  logic [PW-1:0] dr_q;
  logic [VW-1:0] quo_q;
  logic signed [VW-1:0] res_v_q;
  logic res_s_q;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [TW-1:0] t_rd;
  logic [VW-1:0] v_rd;
  logic signed [VW-1:0] lval;

  assign we = (state_q == S_LWR) && ({{(32-IW){1'b0}}, lidx_q} < 32'(MAX_POINTS));
  assign waddr = AW'(lidx_q);

  pwi_ram #(.WIDTH(TW), .DEPTH(MAX_POINTS)) u_time_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(ltime_q), .raddr_i(raddr), .rdata_o(t_rd)
  );
  pwi_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_value_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(lval), .raddr_i(raddr), .rdata_o(v_rd)
  );

  // load value: raw value, or rounded, saturated product when scaling
  logic [43:0] lr;
  assign lr = 44'((lprod_q + 60'h8000) >> 16);
  always_comb begin
    if (!scale_q) lval = VW'(signed'(lmag_q));
    else if (neg_q) lval = (lr >= 44'h80_0000_0000) ? {1'b1, {(VW-1){1'b0}}}
                                                     : -signed'(VW'(lr));
    else lval = (lr > 44'h7F_FFFF_FFFF) ? {1'b0, {(VW-1){1'b1}}} : VW'(lr);
  end

  logic [AW-1:0] last_idx;
  assign last_idx = AW'(n_q - CW'(1));

  always_comb begin
    raddr = k_q;
  end

  assign in_if.ready = (state_q == S_IDLE);
  assign out_if.valid = (state_q == S_OUT);
  assign out_if.value = res_v_q;
  assign out_if.status = res_s_q;

  logic [TW:0] rsh;
  logic [PW:0] dsub;
  logic signed [VW+1:0] dwide;
  assign rsh = {rem_q, qt_q[TW-1]};
  assign dsub = {dr_q, acc_q[PW-1]} - {1'b0, {(PW-TW){1'b0}}, den_q};
  assign dwide = {{2{quo_q[VW-1]}}, quo_q} - {{2{va_q[VW-1]}}, va_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q <= '0;
      init_q <= '0;
      scale_q <= 1'b0;
      use_init_q <= 1'b1;
      k_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (pwi_pkg::reg_idx_e'(cfg_idx_i))
          pwi_pkg::REG_POINT_COUNT:
            n_q <= (32'(cfg_data_i[6:0]) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                             : CW'(cfg_data_i[6:0]);
          pwi_pkg::REG_INITIAL_VALUE: init_q <= signed'(cfg_data_i[VW-1:0]);
          pwi_pkg::REG_SCALE_TO_CGS: scale_q <= cfg_data_i[0];
          pwi_pkg::REG_USE_INITIAL: use_init_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: if (in_if.valid) begin
          lidx_q <= in_if.point_index;
          ltime_q <= in_if.point_time;
          neg_q <= in_if.point_value[RAW_W_L-1];
          lmag_q <= (scale_q && in_if.point_value[RAW_W_L-1]) ? -in_if.point_value
                                                                : in_if.point_value;
          qt_q <= in_if.query_time;
          if (in_if.action == pwi_pkg::ACT_LOAD) begin
            state_q <= S_LMUL;
          end else if (in_if.query_time == '0 && use_init_q) begin
            res_v_q <= init_q; res_s_q <= pwi_pkg::STATUS_OK; state_q <= S_OUT;
          end else if (n_q < CW'(2)) begin
            res_v_q <= '0; res_s_q <= pwi_pkg::STATUS_NOT_PRESCRIBED; state_q <= S_OUT;
          end else begin
            k_q <= last_idx; state_q <= S_QRD;
          end
        end
        S_LMUL: begin
          lprod_q <= 60'(lmag_q) * 60'(pwi_pkg::CGS_SCALE_Q16);
          state_q <= S_LWR;
        end
        S_LWR: state_q <= S_IDLE;
        S_QRD: begin
          state_q <= S_QMOD; cnt_q <= 7'd0; rem_q <= '0;
          per_q <= '0;
        end
        S_QMOD: begin
          if (cnt_q == 7'd0) begin
            per_q <= t_rd; vlast_q <= signed'(v_rd); cnt_q <= 7'd1;
          end else if (per_q == '0) begin
            t_q <= '0; k_q <= '0; state_q <= S_RD0;
          end else begin
            qt_q <= qt_q << 1;
            if (rsh >= {1'b0, per_q}) rem_q <= TW'(rsh - {1'b0, per_q});
            else rem_q <= TW'(rsh);
            if (cnt_q == 7'(TW)) begin
              t_q <= (rsh >= {1'b0, per_q}) ? TW'(rsh - {1'b0, per_q}) : TW'(rsh);
              k_q <= '0; state_q <= S_RD0;
            end
            cnt_q <= cnt_q + 7'd1;
          end
        end
        S_RD0: state_q <= S_WALK;
        S_WALK: begin
          // rd holds entry k
          if (k_q == '0 && t_q <= t_rd) begin
            va_q <= vlast_q; num_q <= t_q; den_q <= t_rd;
            mag_q <= '0;
            state_q <= S_MUL; cnt_q <= 7'd0;
            ta_q <= '0;
            quo_q <= VW'(v_rd);
          end else if (k_q == last_idx) begin
            res_v_q <= vlast_q; res_s_q <= pwi_pkg::STATUS_OK; state_q <= S_OUT;
          end else begin
            ta_q <= t_rd; va_q <= signed'(v_rd);
            k_q <= k_q + AW'(1); state_q <= S_WALK2; cnt_q <= 7'd0;
          end
        end
        S_WALK2: begin
          if (cnt_q == 7'd0) cnt_q <= 7'd1;
          else if (t_q >= ta_q && t_q <= t_rd) begin
            num_q <= t_q - ta_q; den_q <= t_rd - ta_q;
            quo_q <= VW'(v_rd); state_q <= S_MUL; cnt_q <= 7'd0;
          end else begin
            ta_q <= t_rd; va_q <= signed'(v_rd);
            if (k_q == last_idx) begin
              res_v_q <= vlast_q; res_s_q <= pwi_pkg::STATUS_OK; state_q <= S_OUT;
            end else begin
              k_q <= k_q + AW'(1); cnt_q <= 7'd0;
            end
          end
        end
        S_MUL: begin
          if (cnt_q == 7'd0) begin
            dneg_q <= dwide[VW+1];
            mag_q <= dwide[VW+1] ? (VW+1)'(-dwide) : (VW+1)'(dwide);
            acc_q <= '0; bit_q <= '0; cnt_q <= 7'd1;
            if (den_q == '0) begin
              res_v_q <= va_q; res_s_q <= pwi_pkg::STATUS_OK; state_q <= S_OUT;
            end
          end else begin
            if (num_q[TW-1 - bit_q[$clog2(TW)-1:0]])
              acc_q <= (acc_q << 1) + PW'(mag_q);
            else acc_q <= acc_q << 1;
            if (bit_q == SW'(TW-1)) begin
              state_q <= S_DIV; bit_q <= '0; dr_q <= '0;
            end else bit_q <= bit_q + SW'(1);
          end
        end
        S_DIV: begin
          acc_q <= acc_q << 1;
          if (!dsub[PW]) begin
            dr_q <= PW'(dsub); quo_q <= {quo_q[VW-2:0], 1'b1};
          end else begin
            dr_q <= {dr_q[PW-2:0], acc_q[PW-1]}; quo_q <= {quo_q[VW-2:0], 1'b0};
          end
          if (bit_q == SW'(PW-1)) begin
            state_q <= S_OUT; res_s_q <= pwi_pkg::STATUS_OK;
            res_v_q <= dneg_q ? va_q - signed'({quo_q[VW-2:0], !dsub[PW]})
                              : va_q + signed'({quo_q[VW-2:0], !dsub[PW]});
          end
          bit_q <= bit_q + SW'(1);
        end
        S_OUT: if (out_if.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.value)) else $error("hold");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("overlap");
  a_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !out_if.valid) else $error("write during result");
`endif
endmodule

// ----- tb/sv/pwi_result_checker.sv -----
`timescale 1ns / 1ps
module pwi_result_checker
  import pwi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  pwi_in_if                    in_mon,
  pwi_out_if                   out_mon,
  output int                   mismatches,
  output int                   outstanding,
  output int                   results_seen
);
  localparam int TABLE_DEPTH = 64;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } wave_result_t;

  wave_result_t expected_q[$];

  logic [31:0]               time_tab [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] value_tab[TABLE_DEPTH];
  logic [6:0]                count_reg;
  logic signed [VALUE_W-1:0] init_reg;
  logic                      scale_reg;
  logic                      use_init_reg;

  function automatic logic signed [VALUE_W-1:0] cgs_load(logic signed [31:0] raw);
    longint      r0;
    logic [63:0] mag;
    logic [63:0] r;
    r0 = raw;
    if (!scale_reg) return VALUE_W'(r0);
    mag = (r0 < 0) ? 64'(-r0) : 64'(r0);
    r = (mag * 64'(CGS_SCALE_Q16) + 64'h8000) >> 16;
    if (r0 < 0) begin
      if (r >= 64'h80_0000_0000) return 40'h80_0000_0000;
      return VALUE_W'(-longint'(r));
    end
    if (r > 64'h7F_FFFF_FFFF) return 40'h7F_FFFF_FFFF;
    return r[VALUE_W-1:0];
  endfunction

  // va + sign(d) * floor(|d| * num / den), exact
  function automatic longint segment_lerp(longint va, longint vb, logic [31:0] num,
                                          logic [31:0] den);
    longint       d;
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [63:0]  q;
    if (den == 0) return va;
    d = vb - va;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    prod = 128'(mag) * 128'(num);
    q = 64'(prod / 128'(den));
    return (d < 0) ? va - longint'(q) : va + longint'(q);
  endfunction

  function automatic longint interp_value(logic [31:0] qt, int n);
    logic [31:0] period;
    logic [31:0] t;
    longint      va;
    longint      vb;
    period = time_tab[n-1];
    t = (period == 0) ? 32'd0 : qt % period;
    if (t <= time_tab[0]) begin
      va = value_tab[n-1];
      vb = value_tab[0];
      return segment_lerp(va, vb, t, time_tab[0]);
    end
    for (int k = 0; k + 1 < n; k++) begin
      if (t >= time_tab[k] && t <= time_tab[k+1]) begin
        va = value_tab[k];
        vb = value_tab[k+1];
        return segment_lerp(va, vb, t - time_tab[k], time_tab[k+1] - time_tab[k]);
      end
    end
    return value_tab[n-1];
  endfunction

  function automatic wave_result_t predict_query(logic [31:0] qt);
    int           n;
    wave_result_t r;
    n = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
    if (qt == 0 && use_init_reg) begin
      r.value = init_reg;
      r.status = STATUS_OK;
    end else if (n < 2) begin
      r.value = '0;
      r.status = STATUS_NOT_PRESCRIBED;
    end else begin
      r.value = VALUE_W'(interp_value(qt, n));
      r.status = STATUS_OK;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wave_result_t exp_r;
    if (!rst_ni) begin
      count_reg = '0;
      init_reg = '0;
      scale_reg = 1'b0;
      use_init_reg = 1'b1;
      expected_q.delete();
      mismatches = 0;
      outstanding = 0;
      results_seen = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result beat: value %0d status %0b", $time,
                   $signed(out_mon.value), out_mon.status);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_mon.value !== exp_r.value) begin
            mismatches++;
            $display("%0t value mismatch: expected %0d actual %0d", $time,
                     $signed(exp_r.value), $signed(out_mon.value));
          end
          if (out_mon.status !== exp_r.status) begin
            mismatches++;
            $display("%0t status mismatch: expected %0b actual %0b", $time,
                     exp_r.status, out_mon.status);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == ACT_QUERY) begin
          expected_q.push_back(predict_query(in_mon.query_time));
        end else begin
          time_tab[in_mon.point_index] = in_mon.point_time;
          value_tab[in_mon.point_index] = cgs_load(in_mon.point_value);
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_POINT_COUNT: count_reg = cfg_data_i[6:0];
          REG_INITIAL_VALUE: init_reg = cfg_data_i[VALUE_W-1:0];
          REG_SCALE_TO_CGS: scale_reg = cfg_data_i[0];
          REG_USE_INITIAL: use_init_reg = cfg_data_i[0];
          default: ;
        endcase
      end
      outstanding = expected_q.size();
    end
  end
endmodule

// ----- tb/sv/periodic_waveform_interpolator_unit_test.sv -----
`timescale 1ns / 1ps
module periodic_waveform_interpolator_unit_test;
  import pwi_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int ITEM_TARGET = 1250;
  localparam int QUIET_ITEMS = 150;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 24;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  always #4 clk_i = ~clk_i;

  pwi_in_if  in_ch ();
  pwi_out_if out_ch ();

  periodic_waveform_interpolator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  int mismatches;
  int outstanding;
  int results_seen;

  pwi_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  int          items_sent;
  int          loads_sent;
  int          queries_sent;
  int          phases;
  bit          quiet;
  int          stall_left;
  int          idle_cycles;
  int          cur_count;
  logic [31:0] slot_time[TABLE_DEPTH];

  // result side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("periodic_waveform_interpolator_unit_test: done, errors");
        $finish;
      end
    end
  end

  task automatic send(input logic act, input logic [5:0] idx, input logic [31:0] pt,
                      input logic [31:0] pv, input logic [31:0] qt);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.point_index <= idx;
    in_ch.point_time <= pt;
    in_ch.point_value <= pv;
    in_ch.query_time <= qt;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    if (act == ACT_QUERY) queries_sent++;
    else loads_sent++;
  endtask

  task automatic load_point(input int idx, input logic [31:0] t, input logic [31:0] v);
    slot_time[idx] = t;
    send(ACT_LOAD, 6'(idx), t, v, $urandom);
  endtask

  task automatic query(input logic [31:0] t);
    send(ACT_QUERY, 6'($urandom), $urandom, $urandom, t);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e r, input logic [CFG_W-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (r == REG_POINT_COUNT) cur_count = int'(d[6:0]);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // ascending unless scrambled; a zero step gives a zero-width segment
  task automatic fill_table(input int n, input bit scrambled);
    logic [31:0] t;
    logic [31:0] step_max;
    t = 32'($urandom_range(0, 3)) * 32'($urandom_range(0, 500));
    step_max = $urandom_range(0, 1) ? 32'd2000 : 32'hFFFF_FFFF / 32'(n + 1);
    for (int i = 0; i < n; i++) begin
      if (scrambled) t = $urandom;
      else if (i > 0) t = t + (($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, step_max));
      load_point(i, t, pick_value());
    end
  endtask

  function automatic logic [31:0] pick_query();
    int          n;
    logic [31:0] p;
    n = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : cur_count;
    p = (n >= 1) ? slot_time[n-1] : 32'd0;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return slot_time[$urandom_range(0, TABLE_DEPTH - 1)];
      3: return p * 32'($urandom_range(1, 3));
      4: return $urandom;
      default: return $urandom_range(0, p);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_initial();
    case ($urandom_range(0, 5))
      0: return 40'h7F_FFFF_FFFF;
      1: return 40'h80_0000_0000;
      default: return 40'({$urandom, $urandom});
    endcase
  endfunction

  initial begin
    int n;
    int burst;
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_POINT_COUNT;
    cfg_data_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_LOAD;
    in_ch.point_index <= '0;
    in_ch.point_time <= '0;
    in_ch.point_value <= '0;
    in_ch.query_time <= '0;
    quiet = 1'b0;
    cur_count = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) slot_time[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: time zero returns the initial value, anything else is not prescribed
    query(32'd0);
    query(32'd5);
    settle();
    write_reg(REG_USE_INITIAL, 40'd0);
    query(32'd0);
    settle();
    write_reg(REG_POINT_COUNT, 40'd1);
    query(32'hFFFF_FFFF);
    settle();

    // every slot gets written here so no later query reads an unwritten entry
    for (int i = 0; i < TABLE_DEPTH; i++)
      load_point(i, 32'(i) * 32'h0100_0000 + 32'h10,
                 (i % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000);
    load_point(5, slot_time[4], 32'd0);
    settle();
    write_reg(REG_POINT_COUNT, 40'd127);
    write_reg(REG_INITIAL_VALUE, 40'h7F_FFFF_FFFF);
    write_reg(REG_USE_INITIAL, 40'd1);
    query(32'd0);
    query(32'd1);
    query(32'd8);
    query(slot_time[63]);
    query(slot_time[4] + 32'd1);
    query(32'hFFFF_FFFF);
    settle();
    write_reg(REG_INITIAL_VALUE, 40'h80_0000_0000);
    write_reg(REG_SCALE_TO_CGS, 40'd1);
    write_reg(REG_POINT_COUNT, 40'd2);
    query(32'd0);
    load_point(0, 32'd0, 32'h7FFF_FFFF);
    load_point(1, 32'd0, 32'h8000_0000);
    query(32'd77);
    load_point(1, 32'h0001_0000, 32'h0000_0001);
    query(32'h0000_8000);
    query(32'h0003_0000);
    settle();

    while (items_sent < ITEM_TARGET) begin
      phases++;
      if (items_sent >= ITEM_TARGET - QUIET_ITEMS) quiet = 1'b1;
      case ($urandom_range(0, 7))
        0: n = 0;
        1: n = 1;
        2: n = 2;
        3: n = 64;
        4: n = $urandom_range(65, 127);
        default: n = $urandom_range(3, 63);
      endcase
      write_reg(REG_SCALE_TO_CGS, 40'($urandom_range(0, 1)));
      write_reg(REG_USE_INITIAL, 40'($urandom_range(0, 1)));
      write_reg(REG_INITIAL_VALUE, pick_initial());
      write_reg(REG_POINT_COUNT, 40'(n));
      fill_table((n > TABLE_DEPTH) ? TABLE_DEPTH : n, $urandom_range(0, 5) == 0);
      burst = $urandom_range(15, 40);
      for (int j = 0; j < burst; j++) begin
        if ($urandom_range(0, 4) == 0)
          load_point($urandom_range(0, TABLE_DEPTH - 1), $urandom, pick_value());
        else
          query(pick_query());
      end
      settle();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("covered %0d loads and %0d queries over %0d table settings", loads_sent,
             queries_sent, phases);
    $display("checked %0d result beats, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("periodic_waveform_interpolator_unit_test: done, clean");
    end else begin
      $display("periodic_waveform_interpolator_unit_test: done, errors");
    end
    $finish;
  end
endmodule
